// ===== src/hbc_pkg.sv =====
// Shared types and codes of the hashed buffer cache tag engine.
package hbc_pkg;

    // Fixed field widths of the request and result transfers
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned ENTRY_IDX_W = 7;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned STATUS_W    = 3;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOC     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [KEY_W-1:0]       device;
        logic [KEY_W-1:0]       block_number;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [STAMP_W-1:0]     now;
    } hbc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ENTRY_IDX_W-1:0] result_index;
        logic                   need_disk_read;
    } hbc_rsp_t;

endpackage

// ===== src/hbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/hbc_set_hash.sv =====
// Set index unit: 32-bit sum modulo the set count in three pipelined steps.
module hbc_set_hash
    import hbc_pkg::*;
#(
    parameter int unsigned NUM_SETS = 13
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        start,
    input  logic [KEY_W-1:0]                            sum,
    output logic                                        done,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] set_index
);

    localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    // Residues of the byte weights 2^0, 2^8, 2^16 and 2^24
    localparam logic [15:0] RES0  = 16'(1 % NUM_SETS);
    localparam logic [15:0] RES1  = 16'(256 % NUM_SETS);
    localparam logic [15:0] RES2  = 16'(65536 % NUM_SETS);
    localparam logic [15:0] RES3  = 16'(16777216 % NUM_SETS);
    // Rounded-up reciprocal, exact for every 16-bit folded sum
    localparam int unsigned SHIFT = 16 + $clog2(NUM_SETS);
    localparam logic [17:0] RECIP = 18'(((2 ** SHIFT) + NUM_SETS - 1) / NUM_SETS);

    logic [15:0]      fold_reg, fold_next;
    logic [15:0]      fold_d_reg;
    logic [15:0]      quo_reg, quo_next;
    logic [SET_W-1:0] rem_reg, rem_next;
    logic             step1_reg;
    logic             step2_reg;
    logic             done_reg;
    logic [33:0]      prod;

    // Fold the bytes by their residues, then quotient by reciprocal and remainder
    always_comb begin
        fold_next = 16'(sum[7:0])   * RES0 + 16'(sum[15:8])  * RES1
                  + 16'(sum[23:16]) * RES2 + 16'(sum[31:24]) * RES3;
        prod      = 34'(fold_reg) * 34'(RECIP);
        quo_next  = 16'(prod >> SHIFT);
        rem_next  = SET_W'(fold_d_reg - quo_reg * 16'(NUM_SETS));
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step1_reg <= 1'b0;
            step2_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            step1_reg <= start;
            step2_reg <= step1_reg;
            done_reg  <= step2_reg;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            fold_reg <= fold_next;
        end
        if (step1_reg) begin
            fold_d_reg <= fold_reg;
            quo_reg    <= quo_next;
        end
        if (step2_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign set_index = rem_reg;

endmodule

// ===== src/hashed_buffer_cache_lru.sv =====
// Tag and replacement engine of a set-associative block cache.
//
// Requests come in on the s_ channel (valid/ready) as hbc_req_t: a get looks up
// (device, block_number), release/pin/unpin adjust the reference count of the
// entry named by entry_index. Each request gives one result on the m_ channel
// as hbc_rsp_t: status, the chosen entry handle and the disk-read flag.
// One request is worked at a time. A get passes through the pipelined modulo
// unit, one row read, the tag/victim scan over each way in turn, write-back and
// output load. Release, pin and unpin pass through decode and read, load,
// write-back and output load. The next request is taken the cycle after the
// result is loaded, even while that result still waits in the output register.
// The whole set row lives in one RAM word; the read-modify-write of a request
// finishes before the next request is read, so accesses never overlap.
// Reset clears the per-row valid flags: a row never written reads as all-ones
// tags, zero counts and stamps. No clearing pass is needed.
// While the receiver stalls, the result holds in m_data and a finished request
// waits in its output state until the register frees up.
module hashed_buffer_cache_lru
    import hbc_pkg::*;
#(
    parameter int unsigned NUM_SETS    = 13,
    parameter int unsigned NUM_WAYS    = 5,
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hbc_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hbc_rsp_t m_data
);

    localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    typedef struct packed {
        logic [KEY_W-1:0]       dev;
        logic [KEY_W-1:0]       blk;
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   valid;
        logic [STAMP_W-1:0]     stamp;
    } entry_t;

    typedef entry_t [NUM_WAYS-1:0] row_t;

    localparam entry_t RESET_ENTRY = '{dev: '1, blk: '1, cnt: '0, valid: 1'b0, stamp: '0};

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_HASH   = 7'b0000010,
        S_IDX    = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    hbc_req_t              req_reg, req_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [WAY_W-1:0]      way_reg, way_next;
    logic                  in_range_reg, in_range_next;
    row_t                  row_reg, row_next;
    logic [WAY_W-1:0]      scan_reg, scan_next;
    logic                  hit_reg, hit_next;
    logic [WAY_W-1:0]      hit_way_reg, hit_way_next;
    logic                  free_reg, free_next;
    logic [WAY_W-1:0]      free_way_reg, free_way_next;
    logic [STAMP_W-1:0]    best_reg, best_next;
    hbc_rsp_t              res_reg, res_next;
    logic [NUM_SETS-1:0]   row_ok_reg, row_ok_next;
    logic                  m_valid_reg, m_valid_next;
    hbc_rsp_t              m_data_reg, m_data_next;

    logic                  hash_start;
    logic                  hash_done;
    logic [SET_W-1:0]      hash_set;

    logic                  mem_re, mem_we;
    logic [SET_W-1:0]      mem_raddr;
    row_t                  mem_rdata, mem_wdata;

    logic [SET_W-1:0]      dec_set;
    logic [WAY_W-1:0]      dec_way;
    logic                  dec_in_range;
    entry_t                cur;
    entry_t                upd;
    logic [WAY_W-1:0]      tgt;
    logic [31:0]           idx_full;

    hbc_set_hash #(
        .NUM_SETS (NUM_SETS)
    ) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .sum       (s_data.device + s_data.block_number),
        .done      (hash_done),
        .set_index (hash_set)
    );

    hbc_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (NUM_SETS)
    ) u_rows (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (set_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handle decode: set = index / NUM_WAYS by constant compares
    always_comb begin
        dec_set = '0;
        for (int s = 1; s < NUM_SETS; s++) begin
            if (32'(req_reg.entry_index) >= 32'(s * NUM_WAYS)) begin
                dec_set = SET_W'(s);
            end
        end
        dec_way      = WAY_W'(32'(req_reg.entry_index) - 32'(dec_set) * 32'(NUM_WAYS));
        dec_in_range = 32'(req_reg.entry_index) < 32'(NUM_SETS * NUM_WAYS);
    end

    // Scan and update views of the row
    always_comb begin
        cur = row_reg[scan_reg];
        if (req_reg.mode != MODE_GET) begin
            tgt = way_reg;
        end else if (hit_reg) begin
            tgt = hit_way_reg;
        end else begin
            tgt = free_way_reg;
        end
        idx_full = 32'(set_reg) * 32'(NUM_WAYS) + 32'(tgt);
    end

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        set_next      = set_reg;
        way_next      = way_reg;
        in_range_next = in_range_reg;
        row_next      = row_reg;
        scan_next     = scan_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        free_next     = free_reg;
        free_way_next = free_way_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        row_ok_next   = row_ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        hash_start    = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = set_reg;
        mem_we        = 1'b0;
        mem_wdata     = row_reg;
        upd           = row_reg[tgt];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    if (s_data.mode == MODE_GET) begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end else begin
                        state_next = S_IDX;
                    end
                end
            end

            S_HASH: begin
                if (hash_done) begin
                    set_next   = hash_set;
                    mem_re     = 1'b1;
                    mem_raddr  = hash_set;
                    state_next = S_LOAD;
                end
            end

            S_IDX: begin
                set_next      = dec_set;
                way_next      = dec_way;
                in_range_next = dec_in_range;
                mem_re        = 1'b1;
                mem_raddr     = dec_set;
                state_next    = S_LOAD;
            end

            // Row data arrives; a row never written reads as reset values
            S_LOAD: begin
                if (row_ok_reg[set_reg]) begin
                    row_next = mem_rdata;
                end else begin
                    row_next = {NUM_WAYS{RESET_ENTRY}};
                end
                scan_next  = '0;
                hit_next   = 1'b0;
                free_next  = 1'b0;
                state_next = (req_reg.mode == MODE_GET) ? S_SCAN : S_UPDATE;
            end

            // One way per cycle: first tag match, oldest free way
            S_SCAN: begin
                if (!hit_reg && cur.dev == req_reg.device && cur.blk == req_reg.block_number) begin
                    hit_next     = 1'b1;
                    hit_way_next = scan_reg;
                end
                if (cur.cnt == '0 && (!free_reg || cur.stamp < best_reg)) begin
                    free_next     = 1'b1;
                    free_way_next = scan_reg;
                    best_next     = cur.stamp;
                end
                if (scan_reg == WAY_W'(NUM_WAYS - 1)) begin
                    state_next = S_UPDATE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Modify the target entry and write the row back, except on no free way or an out-of-range handle
            S_UPDATE: begin
                res_next.status         = STATUS_DONE;
                res_next.result_index   = '0;
                res_next.need_disk_read = 1'b0;
                unique case (req_reg.mode)
                    MODE_GET: begin
                        if (hit_reg) begin
                            res_next.result_index   = idx_full[ENTRY_IDX_W-1:0];
                            res_next.need_disk_read = !upd.valid;
                            if (upd.cnt == '1) begin
                                res_next.status = STATUS_OVERFLOW;
                            end else begin
                                upd.cnt = upd.cnt + 1'b1;
                            end
                            upd.stamp = req_reg.now;
                            upd.valid = 1'b1;
                            mem_we    = 1'b1;
                        end else if (free_reg) begin
                            res_next.status         = STATUS_ALLOC;
                            res_next.result_index   = idx_full[ENTRY_IDX_W-1:0];
                            res_next.need_disk_read = 1'b1;
                            upd.dev   = req_reg.device;
                            upd.blk   = req_reg.block_number;
                            upd.cnt   = COUNT_WIDTH'(1);
                            upd.stamp = req_reg.now;
                            upd.valid = 1'b1;
                            mem_we    = 1'b1;
                        end else begin
                            res_next.status = STATUS_NO_FREE;
                        end
                    end
                    MODE_PIN: begin
                        if (in_range_reg) begin
                            if (upd.cnt == '1) begin
                                res_next.status = STATUS_OVERFLOW;
                            end else begin
                                upd.cnt = upd.cnt + 1'b1;
                            end
                            mem_we = 1'b1;
                        end
                    end
                    MODE_RELEASE, MODE_UNPIN: begin
                        if (in_range_reg) begin
                            if (upd.cnt == '0) begin
                                res_next.status = STATUS_UNDERFLOW;
                            end else begin
                                upd.cnt = upd.cnt - 1'b1;
                            end
                            mem_we = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                mem_wdata      = row_reg;
                mem_wdata[tgt] = upd;
                if (mem_we) begin
                    row_ok_next[set_reg] = 1'b1;
                end
                state_next = S_OUT;
            end

            // Hand the result to the output register once it is free
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            row_ok_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_ok_reg  <= row_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        set_reg      <= set_next;
        way_reg      <= way_next;
        in_range_reg <= in_range_next;
        row_reg      <= row_next;
        scan_reg     <= scan_next;
        hit_reg      <= hit_next;
        hit_way_reg  <= hit_way_next;
        free_reg     <= free_next;
        free_way_reg <= free_way_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/hbc_checker.sv =====
// Port-level checks of the cache tag engine, bound to the top level.
module hbc_checker
    import hbc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input hbc_req_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input hbc_rsp_t m_data
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An allocation always asks for a disk read
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_ALLOC |-> m_data.need_disk_read)
        else $error("allocation without disk read");

    // Disk read only on a get that picked an entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.need_disk_read |->
            m_data.status == STATUS_DONE || m_data.status == STATUS_ALLOC ||
            m_data.status == STATUS_OVERFLOW)
        else $error("disk read flagged on a failed request");

    // No handle on no-free or underflow results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_NO_FREE || m_data.status == STATUS_UNDERFLOW)
            |-> m_data.result_index == '0 && !m_data.need_disk_read)
        else $error("handle reported on a failed request");

    // A request transfer is only taken while no result is being formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

endmodule

bind hashed_buffer_cache_lru hbc_checker u_hbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/hbc_result_checker.sv =====
// Checker for the hashed buffer cache: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module hbc_result_checker
    import hbc_pkg::*;
#(
    parameter int unsigned NUM_SETS    = 13,
    parameter int unsigned NUM_WAYS    = 5,
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  hbc_req_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  hbc_rsp_t    m_data,
    output int unsigned mismatch_count,
    output int unsigned outstanding
);

    localparam int unsigned NUM_ENTRIES = NUM_SETS * NUM_WAYS;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Shadow copy of the tag store, one entry per handle
    logic [KEY_W-1:0]       line_dev    [NUM_ENTRIES];
    logic [KEY_W-1:0]       line_blk    [NUM_ENTRIES];
    logic [COUNT_WIDTH-1:0] pin_count   [NUM_ENTRIES];
    logic                   line_filled [NUM_ENTRIES];
    logic [STAMP_W-1:0]     line_stamp  [NUM_ENTRIES];

    // Results still owed by the block, oldest first
    hbc_rsp_t owed_rsp_q[$];

    // Apply one request to the shadow store and return the result it must give
    function automatic hbc_rsp_t serve_request(hbc_req_t r);
        hbc_rsp_t           rsp;
        logic [KEY_W-1:0]   key_sum;
        logic [STAMP_W-1:0] oldest;
        int unsigned        base;
        int unsigned        e;
        int unsigned        pick;
        logic               found;
        rsp = '0;
        rsp.status = STATUS_DONE;
        if (r.mode == MODE_GET) begin
            key_sum = r.device + r.block_number;
            base = (key_sum % NUM_SETS) * NUM_WAYS;
            found = 1'b0;
            pick = 0;
            oldest = '0;
            // tag lookup, first matching way
            for (int w = 0; w < NUM_WAYS; w++) begin
                e = base + w;
                if (!found && line_dev[e] == r.device && line_blk[e] == r.block_number) begin
                    found = 1'b1;
                    pick = e;
                end
            end
            if (found) begin
                rsp.need_disk_read = !line_filled[pick];
                if (pin_count[pick] == COUNT_MAX) begin
                    rsp.status = STATUS_OVERFLOW;
                end else begin
                    pin_count[pick] = pin_count[pick] + 1'b1;
                end
                line_stamp[pick] = r.now;
                line_filled[pick] = 1'b1;
                rsp.result_index = ENTRY_IDX_W'(pick);
            end else begin
                // victim: unreferenced way with the oldest stamp, lowest way on ties
                for (int w = 0; w < NUM_WAYS; w++) begin
                    e = base + w;
                    if (pin_count[e] == '0 && (!found || line_stamp[e] < oldest)) begin
                        found = 1'b1;
                        oldest = line_stamp[e];
                        pick = e;
                    end
                end
                if (!found) begin
                    rsp.status = STATUS_NO_FREE;
                end else begin
                    line_dev[pick] = r.device;
                    line_blk[pick] = r.block_number;
                    pin_count[pick] = COUNT_WIDTH'(1);
                    line_stamp[pick] = r.now;
                    line_filled[pick] = 1'b1;
                    rsp.status = STATUS_ALLOC;
                    rsp.result_index = ENTRY_IDX_W'(pick);
                    rsp.need_disk_read = 1'b1;
                end
            end
        end else if (r.entry_index < NUM_ENTRIES) begin
            // refcount adjust; handles past the end are ignored
            if (r.mode == MODE_PIN) begin
                if (pin_count[r.entry_index] == COUNT_MAX) begin
                    rsp.status = STATUS_OVERFLOW;
                end else begin
                    pin_count[r.entry_index] = pin_count[r.entry_index] + 1'b1;
                end
            end else if (pin_count[r.entry_index] == '0) begin
                rsp.status = STATUS_UNDERFLOW;
            end else begin
                pin_count[r.entry_index] = pin_count[r.entry_index] - 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : watch
        hbc_rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                line_dev[i] = '1;
                line_blk[i] = '1;
                pin_count[i] = '0;
                line_filled[i] = 1'b0;
                line_stamp[i] = '0;
            end
            owed_rsp_q.delete();
            mismatch_count = 0;
        end else begin
            // result transfer is checked before the request transfer of the same edge
            if (m_valid && m_ready) begin
                if (owed_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = owed_rsp_q.pop_front();
                    report_field("status", 32'(want.status), 32'(m_data.status));
                    report_field("result_index", 32'(want.result_index),
                                 32'(m_data.result_index));
                    report_field("need_disk_read", 32'(want.need_disk_read),
                                 32'(m_data.need_disk_read));
                end
            end
            if (s_valid && s_ready) begin
                owed_rsp_q.push_back(serve_request(s_data));
            end
        end
        outstanding <= owed_rsp_q.size();
    end

endmodule

// ===== dv/hashed_buffer_cache_lru_test.sv =====
// Testbench top for the hashed buffer cache: request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module hashed_buffer_cache_lru_test
    import hbc_pkg::*;
();

    localparam int unsigned NUM_SETS    = 13;
    localparam int unsigned NUM_WAYS    = 5;
    localparam int unsigned COUNT_WIDTH = 8;
    localparam int unsigned LAST_ENTRY  = NUM_SETS * NUM_WAYS - 1;
    localparam int unsigned RANDOM_REQS = 680;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    hbc_req_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hbc_rsp_t    m_data;
    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    int unsigned burst_left;
    int unsigned ready_run = 0;
    int unsigned recent_set;
    logic [STAMP_W-1:0] tick;

    hashed_buffer_cache_lru #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hbc_result_checker #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #1 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side stalls: runs of ready and of stall, lengths random
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    m_ready <= 1'b0;
                    ready_run = $urandom_range(1, 12);
                end
                2: begin
                    m_ready <= 1'b1;
                    ready_run = $urandom_range(20, 60);
                end
                default: begin
                    m_ready <= $urandom_range(0, 1);
                    ready_run = $urandom_range(1, 4);
                end
            endcase
        end else begin
            ready_run = ready_run - 1;
        end
    end

    function automatic hbc_req_t pack_req(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] dev,
                                          logic [KEY_W-1:0] blk,
                                          logic [ENTRY_IDX_W-1:0] idx,
                                          logic [STAMP_W-1:0] now);
        hbc_req_t r;
        r.mode = mode;
        r.device = dev;
        r.block_number = blk;
        r.entry_index = idx;
        r.now = now;
        return r;
    endfunction

    // Send one request in bursts; called and returns at a falling edge
    task automatic push_req(input hbc_req_t r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left = burst_left - 1;
        @(negedge aclk);
    endtask

    // Key drawn mostly from a small pool so hits and full sets happen
    function automatic logic [KEY_W-1:0] pick_key(int unsigned pool);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return KEY_W'($urandom_range(0, pool));
        if (roll < 95) return $urandom;
        return '1;
    endfunction

    task automatic issue_random(input logic filling);
        hbc_req_t    r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (filling) begin
            r.mode = (roll < 65) ? MODE_GET : (roll < 75) ? MODE_PIN :
                     (roll < 90) ? MODE_RELEASE : MODE_UNPIN;
        end else begin
            r.mode = (roll < 30) ? MODE_GET : (roll < 35) ? MODE_PIN :
                     (roll < 70) ? MODE_RELEASE : MODE_UNPIN;
        end
        r.device = pick_key(3);
        r.block_number = pick_key(47);
        // recency stamp mostly advancing, with repeats, jumps and extremes
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            tick = tick + $urandom_range(0, 3);
            r.now = tick;
        end else if (roll < 95) begin
            r.now = $urandom;
        end else begin
            r.now = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end
        // handle: a way of the last set used by a get, any entry, or any 7-bit value, which may lie beyond the end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            r.entry_index = ENTRY_IDX_W'(recent_set * NUM_WAYS + $urandom_range(0, NUM_WAYS - 1));
        end else if (roll < 85) begin
            r.entry_index = ENTRY_IDX_W'($urandom_range(0, LAST_ENTRY));
        end else begin
            r.entry_index = ENTRY_IDX_W'($urandom_range(0, 127));
        end
        if (r.mode == MODE_GET) begin
            recent_set = (r.device + r.block_number) % NUM_SETS;
        end
        push_req(r);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        burst_left = 0;
        recent_set = 0;
        tick = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: hit on reset tags, fill of set 0, no free way, wrap and extremes
        push_req(pack_req(MODE_GET, '1, '1, 7'd0, 32'd5));
        push_req(pack_req(MODE_GET, '1, '1, 7'd127, 32'd6));
        push_req(pack_req(MODE_GET, 32'd0, 32'd0, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd13, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd26, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd39, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd52, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd65, 7'd0, 32'd1));
        push_req(pack_req(MODE_RELEASE, 32'd0, 32'd0, 7'd0, 32'd0));
        push_req(pack_req(MODE_RELEASE, 32'd0, 32'd0, 7'd0, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd65, 7'd0, '1));
        push_req(pack_req(MODE_RELEASE, 32'd0, 32'd0, 7'd0, 32'd0));
        push_req(pack_req(MODE_RELEASE, 32'd0, 32'd0, 7'd1, 32'd0));
        // stamp all ones must lose to stamp zero
        push_req(pack_req(MODE_GET, 32'd0, 32'd78, 7'd0, 32'd7));
        push_req(pack_req(MODE_GET, 32'd0, 32'd65, 7'd0, 32'd8));
        push_req(pack_req(MODE_UNPIN, '1, '1, ENTRY_IDX_W'(LAST_ENTRY), '1));
        push_req(pack_req(MODE_PIN, 32'd0, 32'd0, ENTRY_IDX_W'(LAST_ENTRY), 32'd0));
        push_req(pack_req(MODE_UNPIN, 32'd0, 32'd0, ENTRY_IDX_W'(LAST_ENTRY), 32'd0));
        push_req(pack_req(MODE_PIN, 32'd0, 32'd0, ENTRY_IDX_W'(LAST_ENTRY + 1), 32'd0));
        push_req(pack_req(MODE_RELEASE, '1, '1, 7'd127, '1));
        push_req(pack_req(MODE_UNPIN, 32'd0, 32'd0, 7'd100, 32'd0));
        push_req(pack_req(MODE_GET, '1, 32'd1, 7'd0, 32'd9));
        push_req(pack_req(MODE_GET, 32'h8000_0000, 32'h7fff_ffff, 7'h55, 32'haaaa_aaaa));
        push_req(pack_req(MODE_GET, 32'h5555_5555, 32'haaaa_aaaa, 7'h2a, 32'h5555_5555));

        // Count saturation: pin one entry past the top, then hit it
        repeat (256) push_req(pack_req(MODE_PIN, 32'd0, 32'd0, 7'd2, 32'd0));
        push_req(pack_req(MODE_GET, 32'd0, 32'd26, 7'd0, 32'd10));

        // Random traffic alternating fill and drain phases
        tick = 32'd100;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            issue_random(((n / 100) % 2) == 0);
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
